// File: design/command_frame_deframer_unit_defines.svh
// assertion macros shared by the command frame deframer rtl
// no dependencies; included by the files that carry assertions
`ifndef COMMAND_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define COMMAND_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define CFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define CFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/cfd_pkg.sv
// shared types, codes and constants of the command frame deframer
// no dependencies; used by the parser, the top level and the testbench
`default_nettype none

package cfd_pkg;

   // frame marker bytes
   localparam logic [7:0] START_BYTE = 8'h41;
   localparam logic [7:0] SYNC_BYTE  = 8'h54;

   // register reset values
   localparam logic [15:0] SEED_RESET       = 16'hAB34;
   localparam logic [15:0] TIMEOUT_RESET    = 16'd3000;
   localparam logic [31:0] MAX_LENGTH_RESET = 32'hFFFF_FFFF;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHECKSUM_SEED = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIMEOUT_TICKS = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_LENGTH    = 2'd2;

   // input item kinds
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // result item kinds
   localparam logic KIND_PAYLOAD   = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   // frame status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd3;

   typedef struct packed {
      logic       mode;
      logic [7:0] byte_value;
   } req_item_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  command_code;
      logic [7:0]  payload_byte;
      logic [31:0] payload_index;
      logic [31:0] frame_length;
      logic [1:0]  frame_status;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] checksum_seed;
      logic [15:0] timeout_ticks;
      logic [31:0] max_length;
   } cfg_type;

endpackage

`default_nettype wire

// File: design/cfd_stream_if.sv
// valid/ready stream channel carrying one payload struct per transaction
// payload type comes from cfd_pkg at the instantiation site
`default_nettype none

interface cfd_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/cfd_parser.sv
// frame parser: phase machine, checksum, length and tick counters
// depends on cfd_pkg; state advances only on cycles where enable is high
`default_nettype none

module cfd_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  enable,
   input  wire cfd_pkg::req_item_type item,
   input  wire cfd_pkg::cfg_type      cfg,
   output logic                       res_valid,
   output cfd_pkg::rsp_item_type      res_item
);

   typedef enum logic [6:0] {
      PHASE_HUNT   = 7'b0000001,
      PHASE_WAIT_T = 7'b0000010,
      PHASE_CMD    = 7'b0000100,
      PHASE_LEN    = 7'b0001000,
      PHASE_DATA   = 7'b0010000,
      PHASE_SUM_HI = 7'b0100000,
      PHASE_SUM_LO = 7'b1000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] sum_ff, sum_in;
   logic [31:0] length_ff, length_in;
   logic [1:0]  len_count_ff, len_count_in;
   logic [31:0] data_count_ff, data_count_in;
   logic [7:0]  command_ff, command_in;
   logic [15:0] elapsed_ff, elapsed_in;

   logic        emit;
   logic        emit_kind;
   logic [7:0]  emit_byte;
   logic [1:0]  emit_status;
   logic [15:0] elapsed_sat;
   logic [15:0] sum_lo;

   assign elapsed_sat = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign sum_lo      = sum_ff - {8'h00, item.byte_value};

   // next state and result of the transaction in the input register
   always_comb begin
      phase_in      = phase_ff;
      sum_in        = sum_ff;
      length_in     = length_ff;
      len_count_in  = len_count_ff;
      data_count_in = data_count_ff;
      command_in    = command_ff;
      elapsed_in    = elapsed_ff;
      emit          = 1'b0;
      emit_kind     = cfd_pkg::KIND_FRAME_END;
      emit_byte     = 8'h00;
      emit_status   = cfd_pkg::STATUS_OK;

      if (item.mode == cfd_pkg::MODE_TICK) begin
         // tick: age an open frame, abort once the limit is reached
         if (phase_ff != PHASE_HUNT) begin
            elapsed_in = elapsed_sat;
            if (elapsed_sat >= cfg.timeout_ticks) begin
               phase_in = PHASE_HUNT;
               if (phase_ff != PHASE_WAIT_T) begin
                  emit        = 1'b1;
                  emit_status = cfd_pkg::STATUS_TIMEOUT;
               end
            end
         end
      end else begin
         case (phase_ff)
            PHASE_HUNT: begin
               if (item.byte_value == cfd_pkg::START_BYTE) begin
                  phase_in   = PHASE_WAIT_T;
                  elapsed_in = 16'd0;
               end
            end
            PHASE_WAIT_T: begin
               if (item.byte_value == cfd_pkg::SYNC_BYTE) begin
                  phase_in      = PHASE_CMD;
                  sum_in        = cfg.checksum_seed;
                  data_count_in = 32'd0;
                  length_in     = 32'd0;
                  len_count_in  = 2'd0;
                  command_in    = 8'h00;
               end else begin
                  phase_in = PHASE_HUNT;
               end
            end
            PHASE_CMD: begin
               command_in   = item.byte_value;
               sum_in       = sum_ff + {8'h00, item.byte_value};
               len_count_in = 2'd0;
               phase_in     = PHASE_LEN;
            end
            PHASE_LEN: begin
               // big-endian length, one byte per transaction
               sum_in    = sum_ff + {8'h00, item.byte_value};
               length_in = {length_ff[23:0], item.byte_value};
               if (len_count_ff == 2'd3) begin
                  len_count_in = 2'd0;
                  if (length_in > cfg.max_length) begin
                     phase_in    = PHASE_HUNT;
                     emit        = 1'b1;
                     emit_status = cfd_pkg::STATUS_TOO_LONG;
                  end else if (length_in != 32'd0) begin
                     phase_in = PHASE_DATA;
                  end else begin
                     phase_in = PHASE_SUM_HI;
                  end
               end else begin
                  len_count_in = len_count_ff + 2'd1;
               end
            end
            PHASE_DATA: begin
               sum_in        = sum_ff + {8'h00, item.byte_value};
               emit          = 1'b1;
               emit_kind     = cfd_pkg::KIND_PAYLOAD;
               emit_byte     = item.byte_value;
               data_count_in = data_count_ff + 32'd1;
               if (data_count_in == length_ff) begin
                  phase_in = PHASE_SUM_HI;
               end
            end
            PHASE_SUM_HI: begin
               sum_in   = sum_ff - {item.byte_value, 8'h00};
               phase_in = PHASE_SUM_LO;
            end
            PHASE_SUM_LO: begin
               sum_in      = sum_lo;
               phase_in    = PHASE_HUNT;
               emit        = 1'b1;
               emit_status = (sum_lo != 16'd0) ? cfd_pkg::STATUS_BAD_SUM : cfd_pkg::STATUS_OK;
            end
            default: begin
               phase_in = PHASE_HUNT;
            end
         endcase
      end
   end

   // result fields
   always_comb begin
      res_valid              = enable & emit;
      res_item.item_kind     = emit_kind;
      res_item.command_code  = command_ff;
      res_item.payload_byte  = emit_byte;
      res_item.payload_index = data_count_ff;
      res_item.frame_length  = length_in;
      res_item.frame_status  = emit_status;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_HUNT;
         sum_ff        <= cfd_pkg::SEED_RESET;
         length_ff     <= 32'd0;
         len_count_ff  <= 2'd0;
         data_count_ff <= 32'd0;
         command_ff    <= 8'h00;
         elapsed_ff    <= 16'd0;
      end else if (enable) begin
         phase_ff      <= phase_in;
         sum_ff        <= sum_in;
         length_ff     <= length_in;
         len_count_ff  <= len_count_in;
         data_count_ff <= data_count_in;
         command_ff    <= command_in;
         elapsed_ff    <= elapsed_in;
      end
   end

endmodule

`default_nettype wire

// File: design/command_frame_deframer_unit.sv
// command frame deframer top level: input register, parser, result register, csrs
// depends on cfd_pkg, cfd_stream_if, cfd_parser and the assertion macro header
//
//   channel   direction  handshake    payload
//   req_      in         valid/ready  mode, byte_value
//   rsp_      out        valid/ready  item_kind, command_code, payload_byte,
//                                     payload_index, frame_length, frame_status
//   csr_      in         write enable index, write data (32 bits)
//
// one transaction per clock sustained while rsp is not stalled; req reaches rsp through
// the input register, then the parser into the result register
// the input register advances whenever the result register is empty or being read
// rsp stalls back up through the input register to req_channel.ready
// synchronous reset returns the parser to hunting and csrs to their defaults
`default_nettype none
`include "command_frame_deframer_unit_defines.svh"

module command_frame_deframer_unit (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   cfd_stream_if.sink                                   req_channel,
   cfd_stream_if.source                                 rsp_channel,
   input  wire logic                                    csr_write_enable,
   input  wire logic [cfd_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [cfd_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data
);

   cfd_pkg::cfg_type      cfg_ff;
   logic                  in_valid_ff;
   cfd_pkg::req_item_type in_item_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   cfd_pkg::rsp_item_type rsp_item_ff;
   logic                  process;
   logic                  res_valid;
   cfd_pkg::rsp_item_type res_item;

   // pipeline advance
   assign process           = in_valid_ff & (~rsp_valid_ff | rsp_channel.ready);
   assign req_channel.ready = ~in_valid_ff | process;
   assign rsp_valid_in      = process ? res_valid : (rsp_valid_ff & ~rsp_channel.ready);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.checksum_seed <= cfd_pkg::SEED_RESET;
         cfg_ff.timeout_ticks <= cfd_pkg::TIMEOUT_RESET;
         cfg_ff.max_length    <= cfd_pkg::MAX_LENGTH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            cfd_pkg::CSR_CHECKSUM_SEED: cfg_ff.checksum_seed <= csr_write_data[15:0];
            cfd_pkg::CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_write_data[15:0];
            cfd_pkg::CSR_MAX_LENGTH:    cfg_ff.max_length    <= csr_write_data[31:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_channel.ready) begin
         in_valid_ff <= req_channel.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_channel.valid && req_channel.ready) begin
         in_item_ff <= req_channel.payload;
      end
   end

   cfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .enable    (process),
      .item      (in_item_ff),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_item_ff <= res_item;
      end
   end

   assign rsp_channel.valid   = rsp_valid_ff;
   assign rsp_channel.payload = rsp_item_ff;

   // checks
   `CFD_ASSERT_NEXT(a_accept_fills_input, clock, reset, req_channel.valid && req_channel.ready, in_valid_ff, "accepted transaction did not reach the input register")
   `CFD_ASSERT_NEXT(a_stalled_input_holds, clock, reset, in_valid_ff && !process, in_valid_ff && $stable(in_item_ff), "stalled input register changed")
   `CFD_ASSERT_SAME(a_result_needs_process, clock, reset, res_valid, process, "parser produced a result without advancing")
   `CFD_ASSERT_SAME(a_payload_in_range, clock, reset, res_valid && res_item.item_kind == cfd_pkg::KIND_PAYLOAD, res_item.payload_index < res_item.frame_length && res_item.frame_status == cfd_pkg::STATUS_OK, "payload result outside declared length")

endmodule

`default_nettype wire

// File: tb/cfd_frame_checker.sv
// scoreboard for the command frame deframer: mirrors the csrs, predicts each
// result from accepted req transactions and compares the rsp transactions
// depends on cfd_pkg
module cfd_frame_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  cfd_pkg::req_item_type                    req_item,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  cfd_pkg::rsp_item_type                    rsp_item,
   input  wire logic                                csr_write_enable,
   input  wire logic [cfd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [cfd_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int unsigned                              error_count,
   output int unsigned                              pending_count
);
   import cfd_pkg::*;

   localparam int unsigned REPORT_LIMIT = 10;

   typedef enum logic [2:0] {
      PH_HUNT, PH_WAIT_SYNC, PH_CMD, PH_LEN, PH_DATA, PH_SUM_HIGH, PH_SUM_LOW
   } frame_phase_type;

   // csr mirror
   logic [15:0] seed_reg;
   logic [15:0] timeout_reg;
   logic [31:0] max_len_reg;

   // deframer state mirror
   frame_phase_type phase_q;
   logic [15:0]     running_sum;
   logic [31:0]     declared_len;
   logic [1:0]      len_bytes_seen;
   logic [31:0]     data_seen;
   logic [7:0]      command_q;
   logic [15:0]     ticks_since_start;

   rsp_item_type    deframed_q[$];
   int unsigned     mismatches;

   function automatic rsp_item_type frame_end_item(input logic [1:0] status);
      rsp_item_type r;
      r.item_kind     = KIND_FRAME_END;
      r.command_code  = command_q;
      r.payload_byte  = 8'h00;
      r.payload_index = data_seen;
      r.frame_length  = declared_len;
      r.frame_status  = status;
      return r;
   endfunction

   // advance the mirrored parser by one accepted transaction
   task automatic deframe_item(input req_item_type item);
      rsp_item_type r;
      logic [7:0]   b;
      b = item.byte_value;
      if (item.mode == MODE_TICK) begin
         if (phase_q != PH_HUNT) begin
            if (ticks_since_start != 16'hFFFF) ticks_since_start = ticks_since_start + 16'd1;
            if (ticks_since_start >= timeout_reg) begin
               // no command known before the sync byte, so drop silently
               if (phase_q != PH_WAIT_SYNC) deframed_q.push_back(frame_end_item(STATUS_TIMEOUT));
               phase_q = PH_HUNT;
            end
         end
      end else begin
         case (phase_q)
            PH_HUNT: begin
               if (b == START_BYTE) begin
                  phase_q = PH_WAIT_SYNC;
                  ticks_since_start = 16'd0;
               end
            end
            PH_WAIT_SYNC: begin
               if (b == SYNC_BYTE) begin
                  phase_q = PH_CMD;
                  running_sum = seed_reg;
                  data_seen = 32'd0;
                  declared_len = 32'd0;
                  len_bytes_seen = 2'd0;
                  command_q = 8'h00;
               end else begin
                  phase_q = PH_HUNT;
               end
            end
            PH_CMD: begin
               command_q = b;
               running_sum = running_sum + {8'h00, b};
               len_bytes_seen = 2'd0;
               phase_q = PH_LEN;
            end
            PH_LEN: begin
               running_sum = running_sum + {8'h00, b};
               declared_len = {declared_len[23:0], b};
               if (len_bytes_seen == 2'd3) begin
                  len_bytes_seen = 2'd0;
                  if (declared_len > max_len_reg) begin
                     phase_q = PH_HUNT;
                     deframed_q.push_back(frame_end_item(STATUS_TOO_LONG));
                  end else begin
                     phase_q = (declared_len != 32'd0) ? PH_DATA : PH_SUM_HIGH;
                  end
               end else begin
                  len_bytes_seen = len_bytes_seen + 2'd1;
               end
            end
            PH_DATA: begin
               running_sum = running_sum + {8'h00, b};
               r.item_kind     = KIND_PAYLOAD;
               r.command_code  = command_q;
               r.payload_byte  = b;
               r.payload_index = data_seen;
               r.frame_length  = declared_len;
               r.frame_status  = STATUS_OK;
               deframed_q.push_back(r);
               data_seen = data_seen + 32'd1;
               if (data_seen == declared_len) phase_q = PH_SUM_HIGH;
            end
            PH_SUM_HIGH: begin
               running_sum = running_sum - {b, 8'h00};
               phase_q = PH_SUM_LOW;
            end
            PH_SUM_LOW: begin
               running_sum = running_sum - {8'h00, b};
               phase_q = PH_HUNT;
               deframed_q.push_back(frame_end_item((running_sum != 16'd0) ? STATUS_BAD_SUM
                                                                          : STATUS_OK));
            end
            default: phase_q = PH_HUNT;
         endcase
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         seed_reg = SEED_RESET;
         timeout_reg = TIMEOUT_RESET;
         max_len_reg = MAX_LENGTH_RESET;
         phase_q = PH_HUNT;
         running_sum = SEED_RESET;
         declared_len = 32'd0;
         len_bytes_seen = 2'd0;
         data_seen = 32'd0;
         command_q = 8'h00;
         ticks_since_start = 16'd0;
         deframed_q.delete();
      end else begin
         // csr writes, unmapped indexes fall through
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CHECKSUM_SEED: seed_reg = csr_write_data[15:0];
               CSR_TIMEOUT_TICKS: timeout_reg = csr_write_data[15:0];
               CSR_MAX_LENGTH:    max_len_reg = csr_write_data;
               default: ;
            endcase
         end

         // compare the result transaction with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (deframed_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display({"unexpected result: kind %0d cmd %02h byte %02h",
                            " index %0d len %0d status %0d"},
                           rsp_item.item_kind, rsp_item.command_code, rsp_item.payload_byte,
                           rsp_item.payload_index, rsp_item.frame_length, rsp_item.frame_status);
            end else begin
               want = deframed_q.pop_front();
               if (rsp_item.item_kind !== want.item_kind ||
                   rsp_item.command_code !== want.command_code ||
                   rsp_item.payload_byte !== want.payload_byte ||
                   rsp_item.payload_index !== want.payload_index ||
                   rsp_item.frame_length !== want.frame_length ||
                   rsp_item.frame_status !== want.frame_status) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display({"result mismatch: expected kind %0d cmd %02h byte %02h",
                               " index %0d len %0d status %0d"},
                              want.item_kind, want.command_code, want.payload_byte,
                              want.payload_index, want.frame_length, want.frame_status);
                     $display({"                 actual   kind %0d cmd %02h byte %02h",
                               " index %0d len %0d status %0d"},
                              rsp_item.item_kind, rsp_item.command_code,
                              rsp_item.payload_byte, rsp_item.payload_index,
                              rsp_item.frame_length, rsp_item.frame_status);
                  end
               end
            end
         end

         // predict from the accepted input transaction
         if (req_valid && req_ready) deframe_item(req_item);
      end
      error_count <= mismatches;
      pending_count <= deframed_q.size();
   end
endmodule

// File: tb/tb.sv
// top of the command frame deframer testbench: clock, reset, csr setup, frame
// stimulus with bursty sender and stalling receiver, watchdog and verdict
// depends on cfd_pkg, cfd_stream_if, command_frame_deframer_unit and cfd_frame_checker
module tb;
   import cfd_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_SETTLE = 6;
   localparam int unsigned PAYLOAD_CAP = 48;
   localparam int unsigned TRUNCATE_TIMEOUT_MAX = 64;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 2'd3;

   typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_LONG_STALL} rx_style_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned quiet_cycles;
   int unsigned burst_left;
   int unsigned items_sent;
   int unsigned ticks_in_frame;

   // mirror of what the csrs hold, used to shape frames
   logic [15:0] cur_seed;
   int unsigned cur_timeout;
   logic [31:0] cur_max;

   rx_style_type rx_style;
   logic [31:0]  cycle_count;

   cfd_stream_if #(.payload_type(req_item_type)) req_if ();
   cfd_stream_if #(.payload_type(rsp_item_type)) rsp_if ();

   command_frame_deframer_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_if),
      .rsp_channel      (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   cfd_frame_checker frame_monitor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_if.valid),
      .req_ready        (req_if.ready),
      .req_item         (req_if.payload),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_item         (rsp_if.payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_count      (mismatch_count),
      .pending_count    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver back-pressure, style picked at random whenever the low byte of cycle_count is zero
   initial begin
      rsp_if.ready = 1'b0;
      rx_style = RX_ALWAYS;
      cycle_count = 32'd0;
      forever begin
         @(posedge clock);
         cycle_count <= cycle_count + 32'd1;
         if (cycle_count[7:0] == 8'd0) rx_style <= rx_style_type'($urandom_range(0, 3));
         case (rx_style)
            RX_ALWAYS:     rsp_if.ready <= 1'b1;
            RX_RANDOM:     rsp_if.ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC:   rsp_if.ready <= (cycle_count[2:0] != 3'd5);
            RX_LONG_STALL: rsp_if.ready <= (cycle_count[4:0] < 5'd20);
            default:       rsp_if.ready <= 1'b1;
         endcase
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one req transaction, with random gaps between bursts
   task automatic send_item(input logic item_mode, input logic [7:0] item_byte);
      int unsigned  gap;
      req_item_type item;
      item.mode = item_mode;
      item.byte_value = item_byte;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_if.valid <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   // occasional tick inside a frame, kept below the timeout
   task automatic maybe_tick();
      if ($urandom_range(0, 9) == 0 && ticks_in_frame + 1 < cur_timeout) begin
         send_item(MODE_TICK, 8'($urandom_range(0, 255)));
         ticks_in_frame++;
      end
   endtask

   // cut_at: 0 sends the whole frame, > 0 stops after that many bytes and
   // ticks into a timeout, < 0 picks the cut point at random
   task automatic send_frame(input logic [7:0] cmd, input logic [31:0] len,
                             input bit corrupt, input int cut_at);
      logic [7:0]  frame_bytes[$];
      logic [15:0] sum;
      logic [15:0] flip;
      logic [7:0]  value;
      int unsigned body;
      int unsigned limit;
      int unsigned n;
      frame_bytes = {START_BYTE, SYNC_BYTE, cmd, len[31:24], len[23:16], len[15:8], len[7:0]};
      sum = cur_seed + {8'h00, cmd} + {8'h00, len[31:24]} + {8'h00, len[23:16]}
            + {8'h00, len[15:8]} + {8'h00, len[7:0]};
      if (len <= cur_max) begin
         body = (len > PAYLOAD_CAP) ? PAYLOAD_CAP : len;
         repeat (body) begin
            value = 8'($urandom_range(0, 255));
            frame_bytes.push_back(value);
            sum = sum + {8'h00, value};
         end
         if (len <= PAYLOAD_CAP) begin
            if (corrupt) begin
               flip = 16'($urandom_range(1, 65535));
               sum = sum ^ flip;
            end
            frame_bytes.push_back(sum[15:8]);
            frame_bytes.push_back(sum[7:0]);
         end
      end
      limit = frame_bytes.size();
      if (cut_at < 0) limit = $urandom_range(1, frame_bytes.size() - 1);
      else if (cut_at > 0) limit = cut_at;
      ticks_in_frame = 0;
      for (int i = 0; i < limit; i++) begin
         send_item(MODE_BYTE, frame_bytes[i]);
         if (i + 1 < limit) maybe_tick();
      end
      if (cut_at != 0) begin
         n = (cur_timeout > ticks_in_frame) ? cur_timeout - ticks_in_frame : 1;
         repeat (n) send_item(MODE_TICK, 8'($urandom_range(0, 255)));
      end
   endtask

   // mostly good frames, some with bad sums, timeouts, noise and false starts
   task automatic random_frame();
      int unsigned style;
      int unsigned pick;
      logic [31:0] len;
      logic [7:0]  cmd;
      logic [7:0]  value;
      style = $urandom_range(0, 19);
      pick = $urandom_range(0, 9);
      cmd = 8'($urandom_range(0, 255));
      if (pick < 7) len = $urandom_range(0, 6);
      else if (pick == 7) len = $urandom_range(7, 40);
      else if (pick == 8) len = cur_max + 32'd1;
      else len = (cur_max <= PAYLOAD_CAP) ? cur_max : $urandom_range(0, 3);
      if (style < 13) begin
         send_frame(cmd, len, 1'b0, 0);
      end else if (style < 15) begin
         send_frame(cmd, len, 1'b1, 0);
      end else if (style < 17) begin
         if (cur_timeout <= TRUNCATE_TIMEOUT_MAX) begin
            if ($urandom_range(0, 2) == 0) len = $urandom;
            send_frame(cmd, len, 1'b0, -1);
         end else begin
            send_frame(cmd, len, 1'b0, 0);
         end
      end else if (style < 19) begin
         // line noise between frames, no start byte so nothing gets locked up
         repeat ($urandom_range(1, 6)) begin
            value = 8'($urandom_range(0, 255));
            if (value == START_BYTE) value = value ^ 8'h01;
            if ($urandom_range(0, 2) == 0) send_item(MODE_TICK, value);
            else send_item(MODE_BYTE, value);
         end
      end else begin
         // false start, the second byte is never the sync byte
         value = ($urandom_range(0, 1) == 0) ? START_BYTE : 8'($urandom_range(0, 255));
         if (value == SYNC_BYTE) value = START_BYTE;
         send_item(MODE_BYTE, START_BYTE);
         send_item(MODE_BYTE, value);
      end
   endtask

   task automatic random_frames(input int unsigned count);
      int unsigned start;
      start = items_sent;
      while (items_sent - start < count) random_frame();
   endtask

   // hold the sender until every predicted result is out, then let the pipe settle
   task automatic wait_drain();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] seed, input logic [15:0] timeout,
                            input logic [31:0] max_len, input bit poke_unmapped);
      write_reg(CSR_CHECKSUM_SEED, {16'h0000, seed});
      write_reg(CSR_TIMEOUT_TICKS, {16'h0000, timeout});
      write_reg(CSR_MAX_LENGTH, max_len);
      if (poke_unmapped) write_reg(CSR_UNMAPPED, $urandom);
      csr_write_enable <= 1'b0;
      cur_seed = seed;
      cur_timeout = 32'(timeout);
      cur_max = max_len;
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_CHECKSUM_SEED;
      csr_write_data = '0;
      burst_left = 0;
      items_sent = 0;
      ticks_in_frame = 0;
      cur_seed = SEED_RESET;
      cur_timeout = 32'(TIMEOUT_RESET);
      cur_max = MAX_LENGTH_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset: tick while hunting, false starts, zero length, bad sum
      send_item(MODE_TICK, 8'hFF);
      send_item(MODE_BYTE, START_BYTE);
      send_item(MODE_BYTE, 8'h00);
      send_item(MODE_BYTE, START_BYTE);
      send_item(MODE_BYTE, START_BYTE);
      send_item(MODE_BYTE, SYNC_BYTE);
      send_frame(8'hFF, 32'd0, 1'b0, 0);
      send_frame(8'h00, 32'd1, 1'b1, 0);
      random_frames(90);

      // zero timeout: first tick after the start byte aborts
      wait_drain();
      configure(16'h0000, 16'd0, 32'hFFFF_FFFF, 1'b1);
      send_frame(8'h12, 32'd3, 1'b0, 1);
      send_frame(8'h34, 32'd3, 1'b0, 3);
      send_frame(8'h56, 32'h0102_0304, 1'b0, 5);
      send_frame(8'h78, 32'd2, 1'b0, 9);
      random_frames(80);

      // short timeout and tiny length limit, over-length then a frame right behind
      wait_drain();
      configure(16'hFFFF, 16'd5, 32'd4, 1'b0);
      send_frame(8'hA5, 32'd5, 1'b0, 0);
      send_frame(8'h5A, 32'd4, 1'b0, 0);
      send_frame(8'hC3, 32'hFFFF_FFFF, 1'b0, 0);
      random_frames(90);

      // longest timeout, only empty frames fit
      wait_drain();
      configure(16'($urandom_range(0, 65535)), 16'hFFFF, 32'd0, 1'b0);
      send_frame(8'h01, 32'd0, 1'b0, 0);
      send_frame(8'h02, 32'd1, 1'b0, 0);
      random_frames(60);

      // random seed and timeout with a large limit
      wait_drain();
      configure(16'($urandom_range(0, 65535)), 16'($urandom_range(2, 40)),
                32'h8000_0000 | $urandom, 1'b1);
      random_frames(100);

      wait_drain();
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
